// ===== design/pacdik_pkg.sv =====
// Package for the planar arm inverse kinematics block: types, constants, sine table.
// No dependencies.
`default_nettype none
package pacdik_pkg;
    localparam int DEGREE_STEPS_DEF       = 360;
    localparam int COORD_FRAC_BITS_DEF    = 12;
    localparam int SEARCH_ANGLE_WIDTH_DEF = 12;
    localparam int LINK_W   = 14;
    localparam int COORD_W  = 16;
    localparam int ANG_W    = 10;
    localparam int SINE_BITS = 14;
    localparam int SIN_W    = 16;
    localparam int PROD_W   = LINK_W + SIN_W + 1;
    localparam int SUM_W    = PROD_W + 2;
    localparam int SQ_W     = 2 * SUM_W;
    localparam int DIST_W   = SQ_W + 1;
    localparam int MAX_SW   = 16;

    localparam logic [1:0] REG_UPPER  = 2'd0;
    localparam logic [1:0] REG_MIDDLE = 2'd1;
    localparam logic [1:0] REG_TIP    = 2'd2;
    localparam logic ACT_SEEK = 1'b0;
    localparam logic ACT_JOG  = 1'b1;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_EVAL_BASE, OP_TRY_UP, OP_TRY_DN,
        OP_EVAL, OP_UNDO, OP_COMMIT, OP_ROUND, OP_FINISH, OP_JOG, OP_JOG_FK
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_BASE, ST_BASE_W, ST_UP, ST_UP_W, ST_UP_CHK,
        ST_DN, ST_DN_W, ST_DN_CHK, ST_NEXTJ, ST_FIN, ST_JOG, ST_JOG_W, ST_JOG_EV,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] joint;
        logic       eval_start;
    } dp_cmd_t;

    typedef struct packed {
        logic eval_done;
        logic improved;
        logic at_max;
        logic at_min;
        logic gained;
    } dp_status_t;

    typedef struct packed {
        logic [ANG_W-1:0]   shoulder_angle;
        logic [ANG_W-1:0]   elbow_angle;
        logic [ANG_W-1:0]   wrist_angle;
        logic [COORD_W-1:0] tip_x;
        logic [COORD_W-1:0] tip_y;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
        logic [1:0]         joint_select;
        logic               jog_down;
    } item_t;

    // round(16384*sin(k deg)), k = 0..90
    function automatic logic [14:0] quarter_sine(input logic [6:0] k);
        logic [14:0] t [0:90];
        t = '{15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713,
              15'd1997, 15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406,
              15'd3686, 15'd3964, 15'd4240, 15'd4516, 15'd4790, 15'd5063,
              15'd5334, 15'd5604, 15'd5871, 15'd6138, 15'd6402, 15'd6664,
              15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192,
              15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397, 15'd9630,
              15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
              15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
              15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
              15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
              15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
              15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
              15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
              15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
              15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384};
        if (k > 7'd90)
            return 15'd0;
        return t[k];
    endfunction

    // Sine of an angle already reduced to 0..359
    function automatic logic signed [SIN_W-1:0] sine_red(input logic [8:0] r);
        logic [14:0] q;
        logic        neg;
        if (r <= 9'd90) begin q = quarter_sine(r[6:0]); neg = 1'b0; end
        else if (r <= 9'd180) begin q = quarter_sine(7'(9'd180 - r)); neg = 1'b0; end
        else if (r <= 9'd270) begin q = quarter_sine(7'(r - 9'd180)); neg = 1'b1; end
        else begin q = quarter_sine(7'(9'd360 - r)); neg = 1'b1; end
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction
endpackage
`default_nettype wire

// ===== design/pacdik_stream_if.sv =====
// Valid/ready channel interface carrying a payload of parameter type.
// Depends on nothing.
`default_nettype none
interface pacdik_stream_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pacdik_ctrl.sv =====
// Controller state machine for seek and jog sequencing.
// Depends on pacdik_pkg.
`default_nettype none
module pacdik_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 action,
    output logic                      out_load,
    input  wire logic                 out_busy,
    output pacdik_pkg::dp_cmd_t       cmd,
    input  wire pacdik_pkg::dp_status_t status
);
    pacdik_pkg::ctl_state_t state_reg, state_next;
    logic [1:0] joint_reg, joint_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pacdik_pkg::ST_IDLE;
            joint_reg <= 2'd2;
        end
        else
        begin
            state_reg <= state_next;
            joint_reg <= joint_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        joint_next = joint_reg;
        in_ready = 1'b0;
        out_load = 1'b0;
        cmd.op = pacdik_pkg::OP_NONE;
        cmd.joint = joint_reg;
        cmd.eval_start = 1'b0;
        unique case (state_reg)
            pacdik_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = pacdik_pkg::OP_LOAD;
                    state_next = (action == pacdik_pkg::ACT_JOG) ?
                        pacdik_pkg::ST_JOG : pacdik_pkg::ST_INIT;
                end
            end
            pacdik_pkg::ST_INIT:
            begin
                cmd.op = pacdik_pkg::OP_INIT;
                joint_next = 2'd2;
                state_next = pacdik_pkg::ST_BASE;
            end
            pacdik_pkg::ST_BASE:
            begin
                cmd.op = pacdik_pkg::OP_EVAL_BASE;
                cmd.eval_start = 1'b1;
                state_next = pacdik_pkg::ST_BASE_W;
            end
            pacdik_pkg::ST_BASE_W:
            begin
                if (status.eval_done)
                begin
                    cmd.op = pacdik_pkg::OP_ROUND;
                    state_next = pacdik_pkg::ST_UP;
                end
            end
            pacdik_pkg::ST_UP:
            begin
                if (status.at_max)
                begin
                    cmd.op = pacdik_pkg::OP_TRY_UP;
                    state_next = pacdik_pkg::ST_DN;
                end
                else
                begin
                    cmd.op = pacdik_pkg::OP_TRY_UP;
                    cmd.eval_start = 1'b1;
                    state_next = pacdik_pkg::ST_UP_W;
                end
            end
            pacdik_pkg::ST_UP_W:
                if (status.eval_done)
                    state_next = pacdik_pkg::ST_UP_CHK;
            pacdik_pkg::ST_UP_CHK:
            begin
                if (status.improved)
                begin
                    cmd.op = pacdik_pkg::OP_COMMIT;
                    state_next = pacdik_pkg::ST_UP;
                end
                else
                begin
                    cmd.op = pacdik_pkg::OP_UNDO;
                    state_next = pacdik_pkg::ST_DN;
                end
            end
            pacdik_pkg::ST_DN:
            begin
                if (status.at_min)
                begin
                    cmd.op = pacdik_pkg::OP_TRY_DN;
                    state_next = pacdik_pkg::ST_NEXTJ;
                end
                else
                begin
                    cmd.op = pacdik_pkg::OP_TRY_DN;
                    cmd.eval_start = 1'b1;
                    state_next = pacdik_pkg::ST_DN_W;
                end
            end
            pacdik_pkg::ST_DN_W:
                if (status.eval_done)
                    state_next = pacdik_pkg::ST_DN_CHK;
            pacdik_pkg::ST_DN_CHK:
            begin
                if (status.improved)
                begin
                    cmd.op = pacdik_pkg::OP_COMMIT;
                    state_next = pacdik_pkg::ST_UP;
                end
                else
                begin
                    cmd.op = pacdik_pkg::OP_UNDO;
                    state_next = pacdik_pkg::ST_NEXTJ;
                end
            end
            pacdik_pkg::ST_NEXTJ:
            begin
                if (joint_reg != 2'd0)
                begin
                    joint_next = joint_reg - 2'd1;
                    state_next = pacdik_pkg::ST_UP;
                end
                else if (status.gained)
                begin
                    cmd.op = pacdik_pkg::OP_ROUND;
                    joint_next = 2'd2;
                    state_next = pacdik_pkg::ST_UP;
                end
                else
                    state_next = pacdik_pkg::ST_FIN;
            end
            pacdik_pkg::ST_FIN:
            begin
                cmd.op = pacdik_pkg::OP_FINISH;
                state_next = pacdik_pkg::ST_OUT;
            end
            pacdik_pkg::ST_JOG:
            begin
                cmd.op = pacdik_pkg::OP_JOG;
                state_next = pacdik_pkg::ST_JOG_W;
            end
            pacdik_pkg::ST_JOG_W:
            begin
                cmd.op = pacdik_pkg::OP_JOG_FK;
                cmd.eval_start = 1'b1;
                state_next = pacdik_pkg::ST_JOG_EV;
            end
            pacdik_pkg::ST_JOG_EV:
            begin
                // wait for the forward-kinematics tip
                if (status.eval_done)
                    state_next = pacdik_pkg::ST_OUT;
            end
            pacdik_pkg::ST_OUT:
            begin
                // wait for a free output register
                if (!out_busy)
                begin
                    out_load = 1'b1;
                    state_next = pacdik_pkg::ST_IDLE;
                end
            end
            default: state_next = pacdik_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/pacdik_datapath.sv =====
// Datapath: angle registers, forward kinematics evaluator, distance compare.
// Depends on pacdik_pkg.
`default_nettype none
module pacdik_datapath #(
    parameter int SEARCH_ANGLE_WIDTH = pacdik_pkg::SEARCH_ANGLE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [pacdik_pkg::LINK_W-1:0] cfg_data,
    input  wire pacdik_pkg::item_t             item,
    input  wire pacdik_pkg::dp_cmd_t           cmd,
    output pacdik_pkg::dp_status_t             status,
    output pacdik_pkg::result_t                result
);
    localparam int SW = SEARCH_ANGLE_WIDTH;
    localparam int AW = pacdik_pkg::ANG_W;
    localparam int SUMW = pacdik_pkg::SUM_W;
    localparam logic signed [SW-1:0] AMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] AMIN = {1'b1, {(SW-1){1'b0}}};
    localparam int RND = 1 << (pacdik_pkg::SINE_BITS - 1);

    logic [pacdik_pkg::LINK_W-1:0] len_reg [3];
    logic signed [AW-1:0] rel_reg [3];
    logic signed [SW-1:0] ang_reg [3];
    pacdik_pkg::item_t item_reg;
    logic sat_reg, gain_reg;
    logic undo_up_reg;
    logic [pacdik_pkg::DIST_W-1:0] best_reg, dist_reg;
    logic signed [pacdik_pkg::COORD_W-1:0] rx_reg, ry_reg;

    // evaluator sequencer: 3 links x (cos, sin), then squared distance
    logic [2:0] ev_cnt_reg;
    logic       ev_busy_reg, ev_done_reg, ev_fk_reg;
    logic signed [SW+1:0] ev_ang [3];
    logic signed [SW+1:0] ev_ang_reg;
    logic [8:0] red_reg;
    logic signed [pacdik_pkg::SIN_W-1:0] trig_reg;
    logic signed [pacdik_pkg::PROD_W-1:0] prod_reg;
    logic signed [SUMW-1:0] xs_reg, ys_reg;
    logic [2:0] stage_reg;

    // u mod 360 through a reciprocal multiply, exact for u < 2^18
    function automatic logic [8:0] mod360u(input logic [17:0] u);
        logic [35:0] p;
        logic [9:0]  q;
        logic [17:0] r;
        p = 36'(u) * 36'd93207;
        q = p[34:25];
        r = u - 18'(q) * 18'd360;
        return r[8:0];
    endfunction

    // reduce an angle to 0..359; an offset of 128 turns keeps it positive
    function automatic logic [8:0] reduce(input logic signed [SW+1:0] a);
        logic signed [19:0] v;
        v = 20'(a) + 20'sd46080;
        return mod360u(v[17:0]);
    endfunction

    // truncating remainder by 360
    function automatic logic signed [AW-1:0] rem360(input logic signed [SW+1:0] a);
        logic [19:0] m;
        logic [8:0]  r;
        m = a[SW+1] ? 20'(-a) : 20'(a);
        r = mod360u(m[17:0]);
        return a[SW+1] ? -AW'(r) : AW'(r);
    endfunction

    function automatic logic signed [SW-1:0] clampa(input logic signed [SW+1:0] a,
                                                    output logic hit);
        hit = 1'b0;
        if (a > (SW+2)'(AMAX)) begin hit = 1'b1; return AMAX; end
        if (a < (SW+2)'(AMIN)) begin hit = 1'b1; return AMIN; end
        return SW'(a);
    endfunction

    function automatic logic [pacdik_pkg::SQ_W-1:0] sq(input logic signed [SUMW-1:0] d);
        logic [SUMW-1:0] u;
        u = d[SUMW-1] ? SUMW'(-d) : d;
        return pacdik_pkg::SQ_W'(u) * pacdik_pkg::SQ_W'(u);
    endfunction

    function automatic logic signed [pacdik_pkg::COORD_W-1:0]
        round_sat(input logic signed [SUMW-1:0] v);
        logic signed [SUMW:0] w;
        w = ((SUMW+1)'(v) + RND) >>> pacdik_pkg::SINE_BITS;
        if (w > 32767) return 16'sd32767;
        if (w < -32768) return -16'sd32768;
        return pacdik_pkg::COORD_W'(w);
    endfunction

    // jog fk angles from relative angles; search angles otherwise
    always_comb
    begin
        if (ev_fk_reg)
        begin
            ev_ang[0] = (SW+2)'(rel_reg[0]) + (SW+2)'(90);
            ev_ang[1] = ev_ang[0] + (SW+2)'(rel_reg[1]);
            ev_ang[2] = ev_ang[1] + (SW+2)'(rel_reg[2]);
        end
        else
        begin
            ev_ang[0] = (SW+2)'(ang_reg[0]);
            ev_ang[1] = (SW+2)'(ang_reg[1]);
            ev_ang[2] = (SW+2)'(ang_reg[2]);
        end
    end

    logic signed [SUMW-1:0] tgt_x, tgt_y, dx, dy;
    assign tgt_x = SUMW'($signed(item_reg.target_x)) <<< pacdik_pkg::SINE_BITS;
    assign tgt_y = SUMW'($signed(item_reg.target_y)) <<< pacdik_pkg::SINE_BITS;
    assign dx = xs_reg - tgt_x;
    assign dy = ys_reg - tgt_y;

    // evaluator: cnt 0..5 picks (link, cos/sin); stage pipelines reduce/trig/mul
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_busy_reg <= 1'b0;
            ev_done_reg <= 1'b0;
            ev_cnt_reg  <= '0;
            stage_reg   <= '0;
            ev_fk_reg   <= 1'b0;
        end
        else
        begin
            ev_done_reg <= 1'b0;
            if (cmd.eval_start)
            begin
                ev_busy_reg <= 1'b1;
                ev_cnt_reg  <= '0;
                stage_reg   <= '0;
                ev_fk_reg   <= (cmd.op == pacdik_pkg::OP_JOG_FK);
            end
            else if (ev_busy_reg)
            begin
                stage_reg <= stage_reg + 3'd1;
                if (stage_reg == 3'd4)
                begin
                    stage_reg <= '0;
                    if (ev_cnt_reg == 3'd6)
                    begin
                        ev_busy_reg <= 1'b0;
                        ev_done_reg <= 1'b1;
                    end
                    ev_cnt_reg <= ev_cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            xs_reg <= '0;
            ys_reg <= '0;
        end
        else if (ev_busy_reg && ev_cnt_reg < 3'd6)
        begin
            case (stage_reg)
                3'd0: ev_ang_reg <= ev_ang[ev_cnt_reg[2:1]]
                                    + (ev_cnt_reg[0] ? (SW+2)'(0) : (SW+2)'(90));
                3'd1: red_reg <= reduce(ev_ang_reg);
                3'd2: trig_reg <= pacdik_pkg::sine_red(red_reg);
                3'd3: prod_reg <= $signed({1'b0, len_reg[ev_cnt_reg[2:1]]}) * trig_reg;
                3'd4:
                begin
                    if (ev_cnt_reg[0]) ys_reg <= ys_reg + SUMW'(prod_reg);
                    else               xs_reg <= xs_reg + SUMW'(prod_reg);
                end
                default: ;
            endcase
        end
        else if (ev_busy_reg && stage_reg == 3'd4)
        begin
            dist_reg <= pacdik_pkg::DIST_W'(sq(dx)) + pacdik_pkg::DIST_W'(sq(dy));
            rx_reg   <= round_sat(xs_reg);
            ry_reg   <= round_sat(ys_reg);
        end
    end

    assign status.eval_done = ev_done_reg;
    assign status.improved  = dist_reg < best_reg;
    assign status.at_max    = ang_reg[cmd.joint] >= AMAX;
    assign status.at_min    = ang_reg[cmd.joint] <= AMIN;
    assign status.gained    = gain_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg[0] <= 14'd8192;
            len_reg[1] <= 14'd5407;
            len_reg[2] <= 14'd3277;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pacdik_pkg::REG_UPPER:  len_reg[0] <= cfg_data;
                pacdik_pkg::REG_MIDDLE: len_reg[1] <= cfg_data;
                pacdik_pkg::REG_TIP:    len_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // angle state and search control
    logic h0, h1, h2;
    logic signed [SW-1:0] c0, c1, c2;
    logic signed [AW:0] jog_sum;
    always_comb
    begin
        c0 = clampa((SW+2)'(rel_reg[0]) + (SW+2)'(90), h0);
        c1 = clampa((SW+2)'(c0) + (SW+2)'(rel_reg[1]), h1);
        c2 = clampa((SW+2)'(c1) + (SW+2)'(rel_reg[2]), h2);
        jog_sum = (AW+1)'(rel_reg[item_reg.joint_select]) +
                  (item_reg.jog_down ? -(AW+1)'(1) : (AW+1)'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_reg[0] <= '0;
            rel_reg[1] <= '0;
            rel_reg[2] <= '0;
            ang_reg[0] <= '0;
            ang_reg[1] <= '0;
            ang_reg[2] <= '0;
            best_reg <= '0;
            undo_up_reg <= 1'b0;
            sat_reg <= 1'b0;
            gain_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                pacdik_pkg::OP_LOAD: sat_reg <= 1'b0;
                pacdik_pkg::OP_INIT:
                begin
                    ang_reg[0] <= c0;
                    ang_reg[1] <= c1;
                    ang_reg[2] <= c2;
                    sat_reg <= h0 | h1 | h2;
                end
                pacdik_pkg::OP_ROUND:
                begin
                    gain_reg <= 1'b0;
                    if (ev_done_reg) best_reg <= dist_reg;
                end
                pacdik_pkg::OP_TRY_UP:
                begin
                    undo_up_reg <= 1'b1;
                    if (ang_reg[cmd.joint] >= AMAX) sat_reg <= 1'b1;
                    else ang_reg[cmd.joint] <= ang_reg[cmd.joint] + SW'(1);
                end
                pacdik_pkg::OP_TRY_DN:
                begin
                    undo_up_reg <= 1'b0;
                    if (ang_reg[cmd.joint] <= AMIN) sat_reg <= 1'b1;
                    else ang_reg[cmd.joint] <= ang_reg[cmd.joint] - SW'(1);
                end
                // step back against the direction of the last try
                pacdik_pkg::OP_UNDO:
                    ang_reg[cmd.joint] <= undo_up_reg ? ang_reg[cmd.joint] - SW'(1)
                                                      : ang_reg[cmd.joint] + SW'(1);
                pacdik_pkg::OP_COMMIT:
                begin
                    best_reg <= dist_reg;
                    gain_reg <= 1'b1;
                end
                pacdik_pkg::OP_FINISH:
                begin
                    rel_reg[0] <= rem360((SW+2)'(ang_reg[0]) - (SW+2)'(90));
                    rel_reg[1] <= rem360((SW+2)'(ang_reg[1]) - (SW+2)'(ang_reg[0]));
                    rel_reg[2] <= rem360((SW+2)'(ang_reg[2]) - (SW+2)'(ang_reg[1]));
                end
                pacdik_pkg::OP_JOG:
                    if (item_reg.joint_select != 2'd3)
                        rel_reg[item_reg.joint_select] <= rem360((SW+2)'(jog_sum));
                default: ;
            endcase
        end
    end

    // item capture on acceptance
    always_ff @(posedge clk)
    begin
        if (cmd.op == pacdik_pkg::OP_LOAD)
            item_reg <= item;
    end

    // result assembly
    always_comb
    begin
        result.shoulder_angle = rel_reg[0];
        result.elbow_angle    = rel_reg[1];
        result.wrist_angle    = rel_reg[2];
        if (item_reg.action == pacdik_pkg::ACT_JOG)
        begin
            result.tip_x = rx_reg;
            result.tip_y = ry_reg;
            result.saturated = 1'b0;
        end
        else
        begin
            result.tip_x = item_reg.target_x;
            result.tip_y = item_reg.target_y;
            result.saturated = sat_reg;
        end
    end
endmodule
`default_nettype wire

// ===== design/planar_arm_coordinate_descent_ik.sv =====
// Planar three-link arm inverse kinematics: top level.
// Depends on pacdik_pkg, pacdik_stream_if, pacdik_ctrl, pacdik_datapath.
//
// Usage: items arrive on in_ch (valid/ready); each gives one result on out_ch.
// Action seek hill-climbs the joint angles one degree at a time toward the
// target; action jog steps one joint and returns the forward-kinematics tip.
// One item is in work at a time. Each tip evaluation runs one shared
// multiplier over 6 products plus a distance phase.
// Link lengths are written through cfg_we/cfg_index/cfg_data while idle.
// Reset clears joint angles to zero and loads default link lengths.
// The result sits in an output register; a stalled receiver holds it, the
// next result waits inside the block and no new item is accepted meanwhile.
`default_nettype none
module planar_arm_coordinate_descent_ik #(
    parameter int SEARCH_ANGLE_WIDTH = pacdik_pkg::SEARCH_ANGLE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [pacdik_pkg::LINK_W-1:0] cfg_data,
    pacdik_stream_if.sink                      in_ch,
    pacdik_stream_if.source                    out_ch
);
    pacdik_pkg::dp_cmd_t    cmd;
    pacdik_pkg::dp_status_t status;
    pacdik_pkg::result_t    result;
    pacdik_pkg::item_t      item;
    logic out_load, out_valid_reg;
    pacdik_pkg::result_t out_reg;

    assign item = in_ch.data;

    pacdik_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .action(item.action), .out_load(out_load), .out_busy(out_valid_reg),
        .cmd(cmd), .status(status)
    );

    pacdik_datapath #(
        .SEARCH_ANGLE_WIDTH(SEARCH_ANGLE_WIDTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .item(item), .cmd(cmd), .status(status),
        .result(result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= result;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
endmodule
`default_nettype wire

// ===== bench/ik_checker.sv =====
// Checker for the planar arm inverse kinematics block: watches both channels
// and the link-length write port, predicts each result and compares it.
// Depends on pacdik_pkg.
`timescale 1ns / 1ps
module ik_checker
    import pacdik_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [LINK_W-1:0] cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  item_t             in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  result_t           out_data,
    output int                fail_count,
    output int                pending
);
    localparam int TURN    = 360;
    localparam int QUARTER = 90;
    localparam int ANG_HI  = (1 << (SEARCH_ANGLE_WIDTH_DEF - 1)) - 1;
    localparam int ANG_LO  = -(1 << (SEARCH_ANGLE_WIDTH_DEF - 1));
    localparam longint UNIT = 64'sd16384;

    // round(16384*sin(k deg)), k = 0..90
    int sine_q [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5871, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384};

    longint  len_upper, len_middle, len_tip;
    int      shoulder, elbow, wrist;
    int      ang [3];
    bit      limit_hit;
    result_t arm_results [$];

    function automatic int sin_deg(int a);
        int r;
        r = a % TURN;
        if (r < 0) r += TURN;
        if (r <= 90) return sine_q[r];
        if (r <= 180) return sine_q[180 - r];
        if (r <= 270) return -sine_q[r - 180];
        return -sine_q[TURN - r];
    endfunction

    function automatic int cos_deg(int a);
        return sin_deg(a + QUARTER);
    endfunction

    // Tip position at Q.(12+14), exact
    function automatic void arm_tip(int a1, int a2, int a3, output longint x,
                                    output longint y);
        x = len_upper * cos_deg(a1) + len_middle * cos_deg(a2) + len_tip * cos_deg(a3);
        y = len_upper * sin_deg(a1) + len_middle * sin_deg(a2) + len_tip * sin_deg(a3);
    endfunction

    function automatic longint unsigned sq_mag(longint d);
        longint unsigned u;
        u = (d < 0) ? longint'(-d) : d;
        return u * u;
    endfunction

    function automatic longint unsigned miss_dist(longint tx, longint ty);
        longint x, y;
        arm_tip(ang[0], ang[1], ang[2], x, y);
        return sq_mag(x - tx * UNIT) + sq_mag(y - ty * UNIT);
    endfunction

    function automatic int clamp_ang(int a);
        if (a > ANG_HI) begin limit_hit = 1; return ANG_HI; end
        if (a < ANG_LO) begin limit_hit = 1; return ANG_LO; end
        return a;
    endfunction

    // Move one joint while a single-degree step strictly lowers the distance
    function automatic void climb(int j, longint tx, longint ty,
                                  inout longint unsigned best);
        longint unsigned d;
        bit moved;
        do begin
            moved = 0;
            if (ang[j] < ANG_HI) begin
                ang[j] += 1;
                d = miss_dist(tx, ty);
                if (d < best) begin best = d; moved = 1; end
                else ang[j] -= 1;
            end
            else limit_hit = 1;
            if (!moved) begin
                if (ang[j] > ANG_LO) begin
                    ang[j] -= 1;
                    d = miss_dist(tx, ty);
                    if (d < best) begin best = d; moved = 1; end
                    else ang[j] += 1;
                end
                else limit_hit = 1;
            end
        end while (moved);
    endfunction

    function automatic longint round_q14(longint v);
        longint w;
        w = v + 8192;
        if (w >= 0) return w >>> 14;
        return -((-w + 16383) >>> 14);
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return COORD_W'(v);
    endfunction

    function automatic result_t arm_predict(item_t it);
        result_t r;
        longint tx, ty, x, y;
        int step, a1;
        tx = $signed(it.target_x);
        ty = $signed(it.target_y);
        r.saturated = 1'b0;
        if (it.action == ACT_SEEK) begin
            longint unsigned b, l;
            limit_hit = 0;
            ang[0] = clamp_ang(shoulder + QUARTER);
            ang[1] = clamp_ang(ang[0] + elbow);
            ang[2] = clamp_ang(ang[1] + wrist);
            b = miss_dist(tx, ty);
            do begin
                l = b;
                climb(2, tx, ty, b);
                climb(1, tx, ty, b);
                climb(0, tx, ty, b);
            end while (b != l);
            shoulder = (ang[0] - QUARTER) % TURN;
            elbow    = (ang[1] - ang[0]) % TURN;
            wrist    = (ang[2] - ang[1]) % TURN;
            r.tip_x = it.target_x;
            r.tip_y = it.target_y;
            r.saturated = limit_hit;
        end
        else begin
            step = it.jog_down ? -1 : 1;
            case (it.joint_select)
                2'd0: shoulder = (shoulder + step) % TURN;
                2'd1: elbow    = (elbow + step) % TURN;
                2'd2: wrist    = (wrist + step) % TURN;
                default: ;
            endcase
            a1 = shoulder + QUARTER;
            arm_tip(a1, a1 + elbow, a1 + elbow + wrist, x, y);
            r.tip_x = sat_coord(round_q14(x));
            r.tip_y = sat_coord(round_q14(y));
        end
        r.shoulder_angle = ANG_W'(shoulder);
        r.elbow_angle    = ANG_W'(elbow);
        r.wrist_angle    = ANG_W'(wrist);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Track configuration, predict on input transactions, check outputs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_upper = 8192; len_middle = 5407; len_tip = 3277;
            shoulder = 0; elbow = 0; wrist = 0;
            arm_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UPPER:  len_upper  = cfg_data;
                    REG_MIDDLE: len_middle = cfg_data;
                    REG_TIP:    len_tip    = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                arm_results.push_back(arm_predict(in_data));
            if (out_valid && out_ready)
            begin
                if (arm_results.size() == 0)
                    report("unexpected transaction", 1, 0);
                else
                begin
                    result_t e;
                    e = arm_results.pop_front();
                    if (out_data.shoulder_angle !== e.shoulder_angle)
                        report("shoulder_angle", $signed(out_data.shoulder_angle),
                               $signed(e.shoulder_angle));
                    if (out_data.elbow_angle !== e.elbow_angle)
                        report("elbow_angle", $signed(out_data.elbow_angle),
                               $signed(e.elbow_angle));
                    if (out_data.wrist_angle !== e.wrist_angle)
                        report("wrist_angle", $signed(out_data.wrist_angle),
                               $signed(e.wrist_angle));
                    if (out_data.tip_x !== e.tip_x)
                        report("tip_x", $signed(out_data.tip_x), $signed(e.tip_x));
                    if (out_data.tip_y !== e.tip_y)
                        report("tip_y", $signed(out_data.tip_y), $signed(e.tip_y));
                    if (out_data.saturated !== e.saturated)
                        report("saturated", out_data.saturated, e.saturated);
                end
            end
            pending = arm_results.size();
        end
    end
endmodule

// ===== bench/testbench.sv =====
// Top of the bench for the planar arm inverse kinematics block: clock, reset,
// stimulus, receiver stalls, watchdog and verdict. Depends on pacdik_pkg,
// pacdik_stream_if, planar_arm_coordinate_descent_ik and ik_checker.
`timescale 1ns / 1ps
module testbench;
    import pacdik_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 400000;
    localparam int SETTLE = 200;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [LINK_W-1:0] cfg_data;
    int                fail_count, pending;
    int                hold_req;
    bit                quiet;
    int                n_seek, n_jog, n_cfg;
    int                walk_x, walk_y;

    pacdik_stream_if #(.payload_t(item_t))   in_ch (clk);
    pacdik_stream_if #(.payload_t(result_t)) out_ch (clk);

    planar_arm_coordinate_descent_ik uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch));

    ik_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_data(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_data(out_ch.data), .fail_count(fail_count), .pending(pending));

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Receiver: long hold-offs on request, otherwise random stall bursts
    initial
    begin
        int burst;
        burst = 0;
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_req--;
                out_ch.ready <= 0;
            end
            else if (!quiet && burst == 0 && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 8) - 1;
                out_ch.ready <= 0;
            end
            else if (burst > 0)
            begin
                burst--;
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= 1;
        end
    end

    // Watchdog: cycles without any transaction
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(item_t it);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_ch.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
        if (it.action == ACT_SEEK) n_seek++;
        else n_jog++;
    endtask

    task automatic seek(int x, int y);
        item_t it;
        it.action = ACT_SEEK;
        it.target_x = 16'(x);
        it.target_y = 16'(y);
        it.joint_select = 2'($urandom_range(0, 3));
        it.jog_down = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic jog(int j, bit down);
        item_t it;
        it.action = ACT_JOG;
        it.target_x = 16'($urandom);
        it.target_y = 16'($urandom);
        it.joint_select = 2'(j);
        it.jog_down = down;
        send_item(it);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 0;
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_links(int up, int mid, int tip);
        drain();
        @(negedge clk);
        cfg_we <= 1; cfg_index <= REG_UPPER; cfg_data <= LINK_W'(up);
        @(negedge clk);
        cfg_index <= REG_MIDDLE; cfg_data <= LINK_W'(mid);
        @(negedge clk);
        cfg_index <= REG_TIP; cfg_data <= LINK_W'(tip);
        @(negedge clk);
        cfg_we <= 0;
        n_cfg += 3;
    endtask

    // Half jogs; the rest mostly small target moves so searches stay short, some jumps
    task automatic random_items(int count, int reach);
        for (int i = 0; i < count; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 50)
                jog($urandom_range(0, 3), $urandom_range(0, 1));
            else if (r < 95)
            begin
                walk_x += $urandom_range(0, 1200) - 600;
                walk_y += $urandom_range(0, 1200) - 600;
                if (walk_x > reach || walk_x < -reach) walk_x = 0;
                if (walk_y > reach || walk_y < -reach) walk_y = reach / 2;
                seek(walk_x, walk_y);
            end
            else
                seek($signed(16'($urandom)), $signed(16'($urandom)));
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_ch.valid = 0; in_ch.data = '0;
        hold_req = 0; quiet = 0;
        n_seek = 0; n_jog = 0; n_cfg = 0;
        walk_x = 0; walk_y = 12000;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: every joint both ways, unused joint code, near and far targets
        for (int j = 0; j < 4; j++)
        begin
            jog(j, 0);
            jog(j, 1);
        end
        seek(0, 16876);
        seek(0, 16876);
        seek(8000, 6000);
        seek(-10000, -4000);
        seek(32767, 32767);
        seek(-32768, -32768);
        seek(-32768, 32767);
        seek(0, 0);
        jog(0, 1);
        jog(2, 0);

        // Receiver holds off while the sender keeps offering jogs
        @(negedge clk);
        hold_req = 600;
        for (int i = 0; i < 6; i++)
            jog($urandom_range(0, 2), $urandom_range(0, 1));
        drain();

        random_items(100, 14000);

        // Longest links, then zero links, plus a write to the unused index
        write_links(16383, 16383, 16383);
        seek(0, 32000);
        random_items(50, 28000);
        write_links(0, 0, 0);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= REG_UNUSED; cfg_data <= '1;
        @(negedge clk);
        cfg_we <= 0;
        n_cfg++;
        seek(5000, -5000);
        random_items(20, 14000);

        // Mixed lengths
        write_links($urandom_range(1, 16383), $urandom_range(1, 16383),
                    $urandom_range(1, 16383));
        walk_x = 0; walk_y = 8000;
        random_items(80, 16000);
        write_links(8192, 5407, 3277);
        walk_x = 0; walk_y = 12000;
        random_items(80, 14000);

        // Final stretch without any idling
        quiet = 1;
        random_items(70, 14000);
        drain();

        $display("covered %0d seeks, %0d jogs, %0d register writes",
                 n_seek, n_jog, n_cfg);
        $display("link settings: reset, all longest, all zero, random; long receiver hold");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
